/* rtl/core/hfn_pkg.sv */
// Shared constants and types for the Hermitian Frobenius norm block.
// Used by the controller, the datapath and the top level.
package hfn_pkg;

   localparam int ENTRY_BITS    = 16;
   localparam int MAX_ORDER     = 256;
   localparam int POS_BITS      = 8;
   localparam int SIZE_BITS     = 9;
   localparam int SQ_BITS       = 2 * ENTRY_BITS;
   localparam int SUM_BITS      = 50;
   localparam int NORM_BITS     = 25;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 9;

   localparam logic [CSR_IDX_BITS-1:0] REG_MATRIX_SIZE    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_UPPER_TRIANGLE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_COMPLEX        = 2'd2;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET    = 9'd256;
   localparam logic [SIZE_BITS-1:0] SIZE_MAX      = 9'd256;
   localparam logic [POS_BITS-1:0]  POS_MAX       = 8'd255;
   localparam logic [SUM_BITS-1:0]  SUM_CAP       = {SUM_BITS{1'b1}};
   localparam logic [SUM_BITS-1:0]  ROOT_START    = 50'd1 << 48;

   typedef struct packed {
      logic accept;
      logic root_step;
      logic load_out;
   } hfn_cmd_type;

   typedef struct packed {
      logic last_item;
      logic root_last;
   } hfn_stat_type;

endpackage

/* rtl/core/hfn_ctrl.sv */
// Controller for the Frobenius norm block: input gating, root sequencing, result beat.
// Depends on hfn_pkg for the command and status structs.
module hfn_ctrl import hfn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  hfn_stat_type stat,
   output hfn_cmd_type  cmd
);

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_ROOT  = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_RUN);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.accept    = req_valid && (state_ff == ST_RUN);
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.load_out  = (state_ff == ST_HOLD) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd.accept && stat.last_item) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (stat.root_last) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_HOLD)
      else $error("result beat raised outside hold");

   a_drain_to_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && cmd.accept && stat.last_item |=> ##1 state_ff == ST_ROOT)
      else $error("last entry did not start the root");

endmodule

/* rtl/core/hfn_dp.sv */
// Datapath for the Frobenius norm block: config registers, positions, squaring,
// accumulation and the bit-serial square root. Depends on hfn_pkg.
module hfn_dp import hfn_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  hfn_cmd_type                     cmd,
   output hfn_stat_type                    stat,
   input  logic                            csr_write,
   input  logic [CSR_IDX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_data,
   input  logic signed [ENTRY_BITS-1:0]    entry_real,
   input  logic signed [ENTRY_BITS-1:0]    entry_imag,
   output logic [NORM_BITS-1:0]            norm_value,
   output logic [SUM_BITS-1:0]             sum_of_squares
);

   logic [SIZE_BITS-1:0]  size_ff;
   logic                  upper_ff;
   logic                  complex_ff;
   logic [POS_BITS-1:0]   row_ff, row_in;
   logic [POS_BITS-1:0]   col_ff, col_in;
   logic [POS_BITS-1:0]   last_pos;
   logic                  used;
   logic [ENTRY_BITS-1:0] mag_re, mag_im;

   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic                  s1_offdiag_ff;
   logic [SQ_BITS-1:0]    sq_re_ff, sq_re_in;
   logic [SQ_BITS-1:0]    sq_im_ff, sq_im_in;

   logic [SQ_BITS:0]      term;
   logic [SUM_BITS:0]     sum_wide;
   logic [SUM_BITS-1:0]   sum_sat;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [SUM_BITS-1:0]   total_ff;

   logic [SUM_BITS-1:0]   rem_ff, rem_in;
   logic [SUM_BITS-1:0]   root_ff, root_in;
   logic [SUM_BITS-1:0]   bit_ff, bit_in;
   logic [SUM_BITS-1:0]   trial;

   logic [NORM_BITS-1:0]  norm_ff;
   logic [SUM_BITS-1:0]   out_sum_ff;

   // clamp the order into 1..MAX_ORDER
   always_comb begin
      priority if (size_ff == '0) begin
         last_pos = '0;
      end else if (size_ff > SIZE_MAX) begin
         last_pos = POS_MAX;
      end else begin
         last_pos = POS_BITS'(size_ff - 9'd1);
      end
   end

   assign used   = upper_ff ? (row_ff <= col_ff) : (row_ff >= col_ff);
   assign mag_re = entry_real[ENTRY_BITS-1] ? (~entry_real + 16'd1) : entry_real;
   assign mag_im = entry_imag[ENTRY_BITS-1] ? (~entry_imag + 16'd1) : entry_imag;

   assign stat.last_item = (row_ff >= last_pos) && (col_ff >= last_pos);
   assign stat.root_last = bit_ff[0];

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (row_ff >= last_pos) begin
         row_in = '0;
         col_in = (col_ff >= last_pos) ? '0 : col_ff + 8'd1;
      end else begin
         row_in = row_ff + 8'd1;
      end
   end

   assign sq_re_in = used ? SQ_BITS'(mag_re) * SQ_BITS'(mag_re) : '0;
   assign sq_im_in = (used && complex_ff) ? SQ_BITS'(mag_im) * SQ_BITS'(mag_im) : '0;

   // stage two: weight, add, saturate
   always_comb begin
      term = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
      if (s1_offdiag_ff) term = {term[SQ_BITS-1:0], 1'b0};
      sum_wide = {1'b0, sum_ff} + (SUM_BITS + 1)'(term);
      sum_sat  = sum_wide[SUM_BITS] ? SUM_CAP : sum_wide[SUM_BITS-1:0];
   end

   assign trial = root_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      priority if (s1_valid_ff && s1_last_ff) begin
         rem_in  = sum_sat;
         root_in = '0;
         bit_in  = ROOT_START;
      end else if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_RESET;
         upper_ff    <= 1'b1;
         complex_ff  <= 1'b0;
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_MATRIX_SIZE:    size_ff    <= csr_data;
               REG_UPPER_TRIANGLE: upper_ff   <= csr_data[0];
               REG_COMPLEX:        complex_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (cmd.accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         s1_valid_ff <= cmd.accept;
         if (s1_valid_ff) begin
            sum_ff <= s1_last_ff ? '0 : sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sq_re_ff      <= sq_re_in;
         sq_im_ff      <= sq_im_in;
         s1_last_ff    <= stat.last_item;
         s1_offdiag_ff <= (row_ff != col_ff);
      end
      if (s1_valid_ff && s1_last_ff) total_ff <= sum_sat;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      if (cmd.load_out) begin
         norm_ff    <= root_ff[NORM_BITS-1:0];
         out_sum_ff <= total_ff;
      end
   end

   assign norm_value     = norm_ff;
   assign sum_of_squares = out_sum_ff;

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && stat.last_item |=> s1_valid_ff && s1_last_ff)
      else $error("last entry lost its flag in stage one");

   a_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> $onehot(bit_ff))
      else $error("root bit is not one-hot");

   a_root_exact: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |->
         (52'(root_ff[NORM_BITS-1:0]) * 52'(root_ff[NORM_BITS-1:0]) <= 52'(total_ff)) &&
         ((52'(root_ff[NORM_BITS-1:0]) + 52'd1) * (52'(root_ff[NORM_BITS-1:0]) + 52'd1)
            > 52'(total_ff)))
      else $error("square root is not the floor root");

endmodule

/* rtl/core/hermitian_frobenius_norm.sv */
// Top level of the streaming Frobenius norm of a Hermitian matrix.
// Depends on hfn_pkg, hfn_ctrl and hfn_dp.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_entry_real, req_entry_imag
//   rsp      out        rsp_valid / rsp_stall  rsp_norm_value, rsp_sum_of_squares
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One entry per cycle while a matrix streams in; squaring and accumulation form
// a two-stage pipe. After the last entry of a matrix, no beat is taken while the
// pipe drains, the one-bit-per-cycle square root runs and the result register is
// loaded. Reset is synchronous and clears the sum and positions. The result
// register holds its beat while rsp_stall is high.
module hermitian_frobenius_norm import hfn_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ENTRY_BITS-1:0]  req_entry_real,
   input  logic signed [ENTRY_BITS-1:0]  req_entry_imag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [NORM_BITS-1:0]          rsp_norm_value,
   output logic [SUM_BITS-1:0]           rsp_sum_of_squares,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   hfn_cmd_type  cmd;
   hfn_stat_type stat;

   assign csr_ready = 1'b1;

   hfn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   hfn_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .entry_real     (req_entry_real),
      .entry_imag     (req_entry_imag),
      .norm_value     (rsp_norm_value),
      .sum_of_squares (rsp_sum_of_squares)
   );

endmodule

/* bench/hfn_norm_checker.sv */
// Checker for the Hermitian Frobenius norm block: watches the entry, result and
// register channels, predicts each norm beat and compares it field by field.
// Depends on hfn_pkg.
`timescale 1ns / 1ps
module hfn_norm_checker import hfn_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [ENTRY_BITS-1:0] req_entry_real,
   input  logic signed [ENTRY_BITS-1:0] req_entry_imag,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [NORM_BITS-1:0]         rsp_norm_value,
   input  logic [SUM_BITS-1:0]          rsp_sum_of_squares,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_data,
   output int                           mismatch_count,
   output int                           norms_pending
);

   typedef struct packed {
      logic [NORM_BITS-1:0] norm;
      logic [SUM_BITS-1:0]  total;
   } norm_beat_type;

   norm_beat_type expected_norms[$];

   logic [SIZE_BITS-1:0] order_cfg;
   logic                 upper_cfg;
   logic                 complex_cfg;
   logic [SUM_BITS-1:0]  running_sum;
   logic [POS_BITS-1:0]  row_at;
   logic [POS_BITS-1:0]  col_at;

   function automatic logic [NORM_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] x);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = 64'(x);
      root  = '0;
      probe = 64'd1 << 50;
      while (probe > rem)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[NORM_BITS-1:0];
   endfunction

   function automatic logic [33:0] squared(input logic signed [ENTRY_BITS-1:0] v);
      logic [ENTRY_BITS:0] mag;
      mag = v[ENTRY_BITS-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
      return 34'(mag) * 34'(mag);
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic accumulate_entry(input logic signed [ENTRY_BITS-1:0] re,
                                   input logic signed [ENTRY_BITS-1:0] im);
      logic [SIZE_BITS-1:0] order;
      logic [SIZE_BITS-1:0] last_pos;
      logic [63:0]          term;
      logic [63:0]          total;
      norm_beat_type        beat;
      order = order_cfg;
      if (order == '0)
         order = SIZE_BITS'(1);
      if (order > MAX_ORDER)
         order = SIZE_BITS'(MAX_ORDER);
      last_pos = order - 1'b1;
      if (upper_cfg ? (row_at <= col_at) : (row_at >= col_at)) begin
         term = 64'(squared(re));
         if (complex_cfg)
            term = term + 64'(squared(im));
         if (term > 64'(SUM_CAP))
            term = 64'(SUM_CAP);
         if (row_at != col_at)
            term = term << 1;
         total = 64'(running_sum) + term;
         if (total > 64'(SUM_CAP))
            total = 64'(SUM_CAP);
         running_sum = total[SUM_BITS-1:0];
      end
      if ({1'b0, row_at} >= last_pos) begin
         row_at = '0;
         if ({1'b0, col_at} >= last_pos) begin
            beat.norm  = floor_root(running_sum);
            beat.total = running_sum;
            expected_norms.push_back(beat);
            running_sum = '0;
            col_at      = '0;
         end else begin
            col_at = col_at + 1'b1;
         end
      end else begin
         row_at = row_at + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      norm_beat_type beat;
      if (reset) begin
         order_cfg   = SIZE_RESET;
         upper_cfg   = 1'b1;
         complex_cfg = 1'b0;
         running_sum = '0;
         row_at      = '0;
         col_at      = '0;
         expected_norms.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_MATRIX_SIZE:    order_cfg   = csr_data;
               REG_UPPER_TRIANGLE: upper_cfg   = csr_data[0];
               REG_COMPLEX:        complex_cfg = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            accumulate_entry(req_entry_real, req_entry_imag);
         if (rsp_valid && !rsp_stall) begin
            if (expected_norms.size() == 0) begin
               report_mismatch("unexpected result beat, sum_of_squares",
                               64'(rsp_sum_of_squares), 64'd0);
            end else begin
               beat = expected_norms.pop_front();
               if (rsp_norm_value !== beat.norm)
                  report_mismatch("norm_value", 64'(rsp_norm_value), 64'(beat.norm));
               if (rsp_sum_of_squares !== beat.total)
                  report_mismatch("sum_of_squares", 64'(rsp_sum_of_squares),
                                  64'(beat.total));
            end
         end
      end
      norms_pending = expected_norms.size();
   end

endmodule

/* bench/tb_hermitian_frobenius_norm.sv */
// Top of the Hermitian Frobenius norm bench: clock, reset, entry and register
// stimulus, result stall pattern and the verdict. Depends on hfn_pkg, the block
// and hfn_norm_checker.
`timescale 1ns / 1ps
module tb_hermitian_frobenius_norm;
   import hfn_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED = 2'd3;
   localparam logic signed [ENTRY_BITS-1:0] MOST_NEG = 16'sh8000;
   localparam logic signed [ENTRY_BITS-1:0] MOST_POS = 16'sh7FFF;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ENTRIES = 300;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [ENTRY_BITS-1:0] req_entry_real = '0;
   logic signed [ENTRY_BITS-1:0] req_entry_imag = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [NORM_BITS-1:0]         rsp_norm_value;
   logic [SUM_BITS-1:0]          rsp_sum_of_squares;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_data = '0;

   int send_idle = 0;
   int recv_idle = 0;
   int hold_left = 0;
   int mismatch_count;
   int norms_pending;

   always #5 clock = ~clock;

   hermitian_frobenius_norm dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_entry_real     (req_entry_real),
      .req_entry_imag     (req_entry_imag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_norm_value     (rsp_norm_value),
      .rsp_sum_of_squares (rsp_sum_of_squares),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   hfn_norm_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_entry_real     (req_entry_real),
      .req_entry_imag     (req_entry_imag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_norm_value     (rsp_norm_value),
      .rsp_sum_of_squares (rsp_sum_of_squares),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .norms_pending      (norms_pending)
   );

   // hold the result channel for a long stretch when asked, else stall at random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   initial begin
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic signed [ENTRY_BITS-1:0] pick_entry();
      unique case ($urandom_range(5))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '0;
         3: return ENTRY_BITS'(int'($urandom_range(15)) - 8);
         default: return ENTRY_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [SIZE_BITS-1:0] pick_size();
      unique case ($urandom_range(9))
         0: return '0;
         1: return SIZE_BITS'(1);
         9: return SIZE_BITS'($urandom_range(12, 7));
         default: return SIZE_BITS'($urandom_range(6, 1));
      endcase
   endfunction

   // entries still needed to close a matrix from row `row` of column 0
   function automatic int entries_to_close(input int row, input int order);
      int last_pos;
      last_pos = order - 1;
      if (last_pos == 0)
         return 1;
      if (row >= last_pos)
         return 1 + last_pos * order;
      return order - row + last_pos * order;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_entry(input logic signed [ENTRY_BITS-1:0] re,
                             input logic signed [ENTRY_BITS-1:0] im);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_entry_real <= re;
      req_entry_imag <= im;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic stream_random(input int count);
      for (int i = 0; i < count; i++)
         send_entry(pick_entry(), pick_entry());
   endtask

   // drop valid, wait for every norm beat, then let the square root drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (norms_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                   sent;
      int                   big;
      int                   k;
      int                   m;
      logic [SIZE_BITS-1:0] small_size;

      send_idle = 37;
      recv_idle = 53;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // size zero behaves as one
      write_reg(REG_COMPLEX, 9'd1);
      write_reg(REG_MATRIX_SIZE, 9'd0);
      send_entry(MOST_NEG, MOST_NEG);
      send_entry(MOST_POS, MOST_POS);
      send_entry(-16'sd1, 16'sd1);
      settle();
      write_reg(REG_COMPLEX, 9'd0);
      write_reg(REG_MATRIX_SIZE, 9'd1);
      send_entry(MOST_NEG, MOST_POS);
      send_entry(16'sd0, MOST_NEG);
      settle();
      write_reg(REG_COMPLEX, 9'd1);
      write_reg(REG_MATRIX_SIZE, 9'd2);
      send_entry(MOST_NEG, MOST_NEG);
      send_entry(MOST_POS, MOST_NEG);
      send_entry(16'sd1, -16'sd1);
      send_entry(MOST_POS, MOST_POS);
      settle();
      write_reg(REG_UPPER_TRIANGLE, 9'd0);
      write_reg(REG_UNUSED, 9'h1FF);
      write_reg(REG_MATRIX_SIZE, 9'd3);
      stream_random(9);
      settle();
      // shrink the order mid-matrix so the row position lands past the end
      write_reg(REG_MATRIX_SIZE, 9'd256);
      stream_random(5);
      settle();
      write_reg(REG_MATRIX_SIZE, 9'd3);
      stream_random(entries_to_close(5, 3));

      for (int phase = 0; phase < 3; phase++) begin
         settle();
         unique case (phase)
            0: begin send_idle = 37; recv_idle = 53; end
            1: begin send_idle = 53; recv_idle = 37; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         sent = 0;
         if (phase == 0) begin
            write_reg(REG_MATRIX_SIZE, 9'd1);
            hold_left = HOLD_CYCLES;
            stream_random(30);
            sent = 30;
         end
         while (sent < PHASE_ENTRIES) begin
            settle();
            if ($urandom_range(7) == 0) begin
               big = int'($urandom_range(511, 13));
               k   = int'($urandom_range(12, 1));
               write_reg(REG_MATRIX_SIZE, CSR_DATA_BITS'(big));
               write_reg(REG_UPPER_TRIANGLE, CSR_DATA_BITS'($urandom_range(1)));
               stream_random(k);
               settle();
               small_size = pick_size();
               write_reg(REG_MATRIX_SIZE, small_size);
               if ($urandom_range(1) != 0)
                  write_reg(REG_COMPLEX, CSR_DATA_BITS'($urandom_range(1)));
               m = (small_size == '0) ? 1 : int'(small_size);
               stream_random(entries_to_close(k, m));
               sent += k + entries_to_close(k, m);
            end else begin
               small_size = pick_size();
               write_reg(REG_MATRIX_SIZE, small_size);
               write_reg(REG_UPPER_TRIANGLE, CSR_DATA_BITS'($urandom_range(1)));
               write_reg(REG_COMPLEX, CSR_DATA_BITS'($urandom_range(1)));
               m = (small_size == '0) ? 1 : int'(small_size);
               for (int rep = int'($urandom_range(3, 1)); rep > 0; rep--) begin
                  stream_random(m * m);
                  sent += m * m;
               end
            end
         end
      end

      // oversized size value: the row wraps at the largest order, then close
      settle();
      write_reg(REG_MATRIX_SIZE, 9'd511);
      write_reg(REG_COMPLEX, 9'd1);
      write_reg(REG_UPPER_TRIANGLE, CSR_DATA_BITS'($urandom_range(1)));
      stream_random(MAX_ORDER + 4);
      settle();
      write_reg(REG_MATRIX_SIZE, 9'd2);
      stream_random(1);
      settle();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
